>>> sv/assert_macros.svh
// Assertion macros used by the checker file.
// Each macro expects clk in scope; AST_IMP and AST_NXT also expect rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked during reset.
`define AST_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, masked during reset.
`define AST_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

// Next-cycle implication that also holds across reset.
`define AST_ALW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> sv/fit_pkg.sv
// Fresnel interface transmission: shared widths, types and register indexes.
// No dependencies.
package fit_pkg;
  localparam int NW     = 16;  // index components and iso index
  localparam int FW     = 18;  // Q2.15 field width
  localparam int DW     = 34;  // positive determinant
  localparam int CW     = 37;  // coefficients
  localparam int PW     = CW + FW;  // partial products
  localparam int MW     = PW + 2;   // numerator magnitude
  localparam int QW     = FW;       // quotient bits per lane
  localparam int RW     = DW + QW;  // divider remainder
  localparam int LANES  = 4;
  localparam int NST    = QW + 6;   // pipeline stages incl. output register
  localparam int CFG_AW = 2;
  localparam logic [NW-1:0] ISO_RST = 16'd6144;

  localparam logic signed [FW-1:0] F_MAX = 18'sd131071;
  localparam logic signed [FW-1:0] F_MIN = -18'sd131072;

  typedef enum logic [CFG_AW-1:0] {
    CFG_ISO  = 2'd0,
    CFG_SIDE = 2'd1
  } cfg_idx_t;

  typedef logic signed [FW-1:0] field_t;
endpackage

>>> sv/fit_if.sv
// Valid/ready channel interfaces for the Fresnel transmission block.
// Depends on fit_pkg.
interface fit_in_if;
  import fit_pkg::*;
  logic valid;
  logic ready;
  logic [NW-1:0] n_xx;
  logic [NW-1:0] n_yy;
  logic signed [NW-1:0] n_xy;
  field_t ex_re;
  field_t ex_im;
  field_t ey_re;
  field_t ey_im;
  modport source (output valid, n_xx, n_yy, n_xy, ex_re, ex_im, ey_re, ey_im, input ready);
  modport sink (input valid, n_xx, n_yy, n_xy, ex_re, ex_im, ey_re, ey_im, output ready);
endinterface

interface fit_out_if;
  import fit_pkg::*;
  logic valid;
  logic ready;
  field_t tx_re;
  field_t tx_im;
  field_t ty_re;
  field_t ty_im;
  logic fault;
  modport source (output valid, tx_re, tx_im, ty_re, ty_im, fault, input ready);
  modport sink (input valid, tx_re, tx_im, ty_re, ty_im, fault, output ready);
endinterface

interface fit_cfg_if;
  import fit_pkg::*;
  logic valid;
  logic ready;
  logic [CFG_AW-1:0] index;
  logic [NW-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> sv/fresnel_interface_transmission.sv
// 24 pipeline stages from input transaction to the result on the output register.
// One pixel per cycle unless the output stalls; the divider is 18 unrolled restoring
// stages, one quotient bit each, four lanes side by side. Stages hold and compress bubbles
// independently, so a stall at the output stops nothing upstream until the pipe is full.
// Reset (rst_n, synchronous, active low) empties the pipe and sets iso_index 1.5, side 0.
module fresnel_interface_transmission (
  input logic clk,
  input logic rst_n,
  fit_in_if.sink    in_ch,
  fit_out_if.source out_ch,
  fit_cfg_if.sink   cfg_ch
);
  import fit_pkg::*;

  logic [NW-1:0] iso_r;
  logic          side_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iso_r  <= ISO_RST;
      side_r <= 1'b0;
    end else if (cfg_ch.valid) begin
      unique case (cfg_idx_t'(cfg_ch.index))
        CFG_ISO:  iso_r  <= cfg_ch.data;
        CFG_SIDE: side_r <= cfg_ch.data[0];
        default: ;
      endcase
    end
  end

  // stage valids and per-stage ready chain
  logic [NST-1:0] v_r;
  logic [NST:0]   rdy;
  logic [NST-1:0] vin;

  always_comb begin
    rdy[NST] = out_ch.ready;
    for (int i = NST - 1; i >= 0; i--) rdy[i] = !v_r[i] || rdy[i+1];
    vin = {v_r[NST-2:0], in_ch.valid};
  end

  assign in_ch.ready = rdy[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int i = 0; i < NST; i++) if (rdy[i]) v_r[i] <= vin[i];
    end
  end

  // S1: sums and first products
  logic [DW-1:0]          ab_r;
  logic signed [31:0]     nn_r;
  logic [32:0]            na_r, nb_r;
  logic signed [32:0]     nnx_r;
  field_t                 e1_r [LANES];
  logic [16:0]            a_c, b_c;

  assign a_c = {1'b0, iso_r} + {1'b0, in_ch.n_xx};
  assign b_c = {1'b0, iso_r} + {1'b0, in_ch.n_yy};

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      ab_r     <= DW'(a_c) * DW'(b_c);
      nn_r     <= 32'(in_ch.n_xy) * 32'(in_ch.n_xy);
      na_r     <= 33'(iso_r) * 33'(a_c);
      nb_r     <= 33'(iso_r) * 33'(b_c);
      nnx_r    <= 33'($signed({1'b0, iso_r})) * 33'(in_ch.n_xy);
      e1_r[0]  <= in_ch.ex_re;
      e1_r[1]  <= in_ch.ex_im;
      e1_r[2]  <= in_ch.ey_re;
      e1_r[3]  <= in_ch.ey_im;
    end
  end

  // S2: determinant and coefficients
  logic signed [35:0]   det_c;
  logic signed [CW-1:0] cx_nxt, cy_nxt, cc_nxt;
  logic signed [CW-1:0] cx_r, cy_r, cc_r;
  logic [DW-1:0]        det2_r;
  logic                 bad2_r;
  field_t               e2_r [LANES];

  always_comb begin
    det_c = $signed({2'b00, ab_r}) - 36'(nn_r);
    if (!side_r) begin
      cx_nxt = $signed({4'b0, nb_r});
      cy_nxt = $signed({4'b0, na_r});
      cc_nxt = -CW'(nnx_r);
    end else begin
      cx_nxt = CW'(det_c) - $signed({4'b0, nb_r});
      cy_nxt = CW'(det_c) - $signed({4'b0, na_r});
      cc_nxt = CW'(nnx_r);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      cx_r   <= cx_nxt;
      cy_r   <= cy_nxt;
      cc_r   <= cc_nxt;
      det2_r <= det_c[DW-1:0];
      bad2_r <= (det_c <= 36'sd0);
      e2_r   <= e1_r;
    end
  end

  // S3: partial products. Lanes: tx_re, tx_im, ty_re, ty_im.
  logic signed [PW-1:0] pa_r [LANES];
  logic signed [PW-1:0] pb_r [LANES];
  logic [DW-1:0]        det3_r;
  logic                 bad3_r;

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      pa_r[0] <= PW'(cx_r) * PW'(e2_r[0]);
      pb_r[0] <= PW'(cc_r) * PW'(e2_r[2]);
      pa_r[1] <= PW'(cx_r) * PW'(e2_r[1]);
      pb_r[1] <= PW'(cc_r) * PW'(e2_r[3]);
      pa_r[2] <= PW'(cy_r) * PW'(e2_r[2]);
      pb_r[2] <= PW'(cc_r) * PW'(e2_r[0]);
      pa_r[3] <= PW'(cy_r) * PW'(e2_r[3]);
      pb_r[3] <= PW'(cc_r) * PW'(e2_r[1]);
      det3_r  <= det2_r;
      bad3_r  <= bad2_r;
    end
  end

  // S4: numerator sign and magnitude
  logic [MW-1:0]     mag_r [LANES];
  logic [LANES-1:0]  neg4_r;
  logic [DW-1:0]     det4_r;
  logic              bad4_r;
  logic signed [MW-1:0] num_c [LANES];

  always_comb begin
    for (int k = 0; k < LANES; k++)
      num_c[k] = (MW'(pa_r[k]) + MW'(pb_r[k])) <<< 1;
  end

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      for (int k = 0; k < LANES; k++) begin
        neg4_r[k] <= num_c[k][MW-1];
        mag_r[k]  <= num_c[k][MW-1] ? MW'(-num_c[k]) : MW'(num_c[k]);
      end
      det4_r <= det3_r;
      bad4_r <= bad3_r;
    end
  end

  // S5 and divider: index 0 is S5, index j+1 is divider stage j
  logic [RW-1:0]    rem_r [QW+1][LANES];
  logic [QW-1:0]    q_r   [QW+1][LANES];
  logic [LANES-1:0] neg_r [QW+1];
  logic [LANES-1:0] big_r [QW+1];
  logic [DW-1:0]    det_r [QW+1];
  logic             bad_r [QW+1];
  logic [MW:0]      madd_c [LANES];
  logic [MW:0]      dful_c;

  always_comb begin
    dful_c = (MW+1)'({det4_r, {QW{1'b0}}});
    for (int k = 0; k < LANES; k++)
      madd_c[k] = (MW+1)'(mag_r[k]) + (MW+1)'(det4_r >> 1);
  end

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      for (int k = 0; k < LANES; k++) begin
        rem_r[0][k] <= madd_c[k][RW-1:0];
        q_r[0][k]   <= '0;
        big_r[0][k] <= (madd_c[k] >= dful_c);
      end
      neg_r[0] <= neg4_r;
      det_r[0] <= det4_r;
      bad_r[0] <= bad4_r;
    end
  end

  for (genvar j = 0; j < QW; j++) begin : g_div
    localparam int BIT = QW - 1 - j;
    logic [RW-1:0] dsh;
    assign dsh = RW'(det_r[j]) << BIT;
    always_ff @(posedge clk) begin
      if (rdy[5+j]) begin
        for (int k = 0; k < LANES; k++) begin
          if (rem_r[j][k] >= dsh) begin
            rem_r[j+1][k] <= rem_r[j][k] - dsh;
            q_r[j+1][k]   <= q_r[j][k] | (QW'(1) << BIT);
          end else begin
            rem_r[j+1][k] <= rem_r[j][k];
            q_r[j+1][k]   <= q_r[j][k];
          end
        end
        neg_r[j+1] <= neg_r[j];
        big_r[j+1] <= big_r[j];
        det_r[j+1] <= det_r[j];
        bad_r[j+1] <= bad_r[j];
      end
    end
  end

  // output register: rounding done, saturate and sign
  field_t           res_r [LANES];
  logic             fault_r;
  field_t           res_c [LANES];
  logic [LANES-1:0] sat_c;
  logic [QW-1:0]    qf;

  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      qf = q_r[QW][k];
      if (neg_r[QW][k]) begin
        sat_c[k] = big_r[QW][k] || (qf > QW'(131072));
        res_c[k] = sat_c[k] ? F_MIN : field_t'(-$signed({1'b0, qf}));
      end else begin
        sat_c[k] = big_r[QW][k] || qf[QW-1];
        res_c[k] = sat_c[k] ? F_MAX : field_t'(qf);
      end
      if (bad_r[QW]) res_c[k] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[NST-1]) begin
      res_r   <= res_c;
      fault_r <= bad_r[QW] || (|sat_c);
    end
  end

  assign out_ch.valid = v_r[NST-1];
  assign out_ch.tx_re = res_r[0];
  assign out_ch.tx_im = res_r[1];
  assign out_ch.ty_re = res_r[2];
  assign out_ch.ty_im = res_r[3];
  assign out_ch.fault = fault_r;
endmodule

>>> sv/fit_checker.sv
// Port-level checks for the Fresnel transmission block, bound to its top level.
// Depends on fit_pkg and assert_macros.svh.
`include "assert_macros.svh"
module fit_checker (
  input logic clk,
  input logic rst_n,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic cfg_valid,
  input logic cfg_ready,
  input fit_pkg::field_t tx_re,
  input logic fault
);
  import fit_pkg::*;

  // a stalled result holds
  `AST_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(tx_re) && $stable(fault))
  // input only back-pressured when the pipe is full behind a stalled result
  `AST_IMP(a_in_stall, !in_ready, out_valid && !out_ready)
  // reset empties the pipe
  `AST_ALW(a_rst_empty, !rst_n, !out_valid)
  // register writes always taken
  `AST_IMP(a_cfg_rdy, cfg_valid, cfg_ready)
endmodule

bind fresnel_interface_transmission fit_checker u_fit_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .cfg_valid (cfg_ch.valid),
  .cfg_ready (cfg_ch.ready),
  .tx_re     (out_ch.tx_re),
  .fault     (out_ch.fault)
);
